[rtl/core/pvc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared modes, code-format constants and types for the prefix varint codec.
// ----------------------------------------------------------------------------
package pvc_pkg;

	// operation codes carried on the mode field
	localparam logic [1:0] MODE_DEC_PLAIN = 2'd0;
	localparam logic [1:0] MODE_DEC_JUMP  = 2'd1;
	localparam logic [1:0] MODE_ENC_VALUE = 2'd2;
	localparam logic [1:0] MODE_ENC_JUMP  = 2'd3;

	// result kinds
	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_VALUE = 1'b1;

	// prefix byte boundaries and tags
	localparam logic [7:0] PFX_2B = 8'h80;
	localparam logic [7:0] PFX_3B = 8'hC0;
	localparam logic [7:0] PFX_4B = 8'hE0;
	localparam logic [7:0] PFX_5B = 8'hF0;

	// payload masks of the prefix byte
	localparam logic [7:0] MASK_2B = 8'h7F;
	localparam logic [7:0] MASK_3B = 8'h3F;
	localparam logic [7:0] MASK_4B = 8'h1F;

	// encoder length thresholds (strictly below)
	localparam logic [31:0] LIM_1B = 32'h0000_007F;
	localparam logic [31:0] LIM_2B = 32'h0000_3FFF;
	localparam logic [31:0] LIM_3B = 32'h001F_FFFF;
	localparam logic [31:0] LIM_4B = 32'h0FFF_FFFF;

	// one emitted code byte from the encoder
	typedef struct packed {
		logic [7:0] code_byte;
		logic       final_byte;
	} pvc_enc_t;

	// decoder outcome for the item in the work register
	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} pvc_dec_t;

endpackage

[rtl/core/pvc_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_encoder
// Builds the code word for a value or a relative jump and selects the code
// byte at a given index, flagging the final one.
// ----------------------------------------------------------------------------
module pvc_encoder
	import pvc_pkg::*;
(
	input  logic [1:0]  mode,
	input  logic [31:0] value_in,
	input  logic [31:0] position,
	input  logic [2:0]  index,
	output pvc_enc_t    enc
);

	logic [31:0] jump_diff;
	logic [31:0] jump_diff_neg;
	logic [31:0] code;
	logic [2:0]  nbytes;
	logic [2:0]  last_idx;
	logic [1:0]  sel;
	logic [7:0]  first_byte;

	// jump distance with the sign moved into bit 0
	assign jump_diff     = value_in - position;
	assign jump_diff_neg = position - value_in;

	always_comb begin
		if (mode == MODE_ENC_JUMP) begin
			if (jump_diff[31]) begin
				code = {jump_diff_neg[30:0], 1'b1};
			end else begin
				code = {jump_diff[30:0], 1'b0};
			end
		end else begin
			code = value_in;
		end
	end

	// code length
	always_comb begin
		if (code < LIM_1B) begin
			nbytes = 3'd1;
		end else if (code < LIM_2B) begin
			nbytes = 3'd2;
		end else if (code < LIM_3B) begin
			nbytes = 3'd3;
		end else if (code < LIM_4B) begin
			nbytes = 3'd4;
		end else begin
			nbytes = 3'd5;
		end
	end

	assign last_idx = nbytes - 3'd1;

	// prefix byte
	always_comb begin
		case (nbytes)
			3'd1:    first_byte = code[7:0];
			3'd2:    first_byte = PFX_2B | code[15:8];
			3'd3:    first_byte = PFX_3B | code[23:16];
			3'd4:    first_byte = PFX_4B | code[31:24];
			default: first_byte = PFX_5B;
		endcase
	end

	// trailing bytes go out big endian
	assign sel = 2'(last_idx - index);

	always_comb begin
		if (index == 3'd0) begin
			enc.code_byte = first_byte;
		end else begin
			enc.code_byte = code[{sel, 3'b000} +: 8];
		end
		enc.final_byte = (index == last_idx);
	end

endmodule

[rtl/core/pvc_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_decoder
// Decode state (accumulator, bytes left, jump flag, base position) and the
// logic that folds in one code byte and forms the finished value or target.
// ----------------------------------------------------------------------------
module pvc_decoder
	import pvc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        update,
	input  logic [1:0]  mode,
	input  logic [7:0]  byte_in,
	input  logic [31:0] position,
	output pvc_dec_t    dec
);

	logic [31:0] acc_q;
	logic [2:0]  left_q;
	logic        jump_q;
	logic [31:0] base_q;

	logic        prefix;
	logic        cur_jump;
	logic [31:0] cur_base;
	logic [31:0] code;
	logic        code_done;
	logic [31:0] code_value;
	logic [30:0] mag;
	logic [31:0] target_fwd;
	logic [31:0] target_bwd;

	assign prefix = (left_q == 3'd0);

	// code word and completion for this byte
	always_comb begin
		if (prefix) begin
			cur_jump  = (mode == MODE_DEC_JUMP);
			cur_base  = position;
			code      = {24'd0, byte_in};
			code_done = (byte_in < PFX_2B);
		end else begin
			cur_jump  = jump_q;
			cur_base  = base_q;
			code      = {acc_q[23:0], byte_in};
			code_done = (left_q == 3'd1);
		end
	end

	// relative target, sign in bit 0
	assign mag        = code[31:1];
	assign target_fwd = cur_base + {1'b0, mag};
	assign target_bwd = cur_base - {1'b0, mag};

	always_comb begin
		if (!cur_jump) begin
			code_value = code;
		end else if (code[0]) begin
			code_value = target_bwd;
		end else begin
			code_value = target_fwd;
		end
	end

	assign dec = '{done: code_done, value: code_value};

	// state update when a decode byte leaves the work register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			left_q <= '0;
			jump_q <= 1'b0;
			base_q <= '0;
		end else if (update) begin
			if (prefix) begin
				jump_q <= cur_jump;
				base_q <= position;
				if (byte_in < PFX_2B) begin
					left_q <= 3'd0;
				end else if (byte_in < PFX_3B) begin
					acc_q  <= {24'd0, byte_in & MASK_2B};
					left_q <= 3'd1;
				end else if (byte_in < PFX_4B) begin
					acc_q  <= {24'd0, byte_in & MASK_3B};
					left_q <= 3'd2;
				end else if (byte_in < PFX_5B) begin
					acc_q  <= {24'd0, byte_in & MASK_4B};
					left_q <= 3'd3;
				end else begin
					acc_q  <= '0;
					left_q <= 3'd4;
				end
			end else begin
				acc_q  <= code;
				left_q <= left_q - 3'd1;
			end
		end
	end

endmodule

[rtl/core/prefix_varint_codec_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_varint_codec_unit
// Prefix varint codec: decodes 1-5 byte codes one byte per transaction and
// encodes values or relative jumps into 1-5 code bytes.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------
//   in      | in_valid, in_stall | mode, byte_in, value_in, position
//   out     | out_valid,out_stall| out_kind, byte_out, value_out, last
//
// A decode byte passes through the work register; an encode holds it until
// its last code byte (1 to 5) is taken by the single output register, and
// every result is registered there before it is shown on the outputs.
// arst_n clears the decode state, the byte index and both valid flags.
// out_stall holds the output register; in_stall rises while the work
// register cannot retire its transaction.
// ----------------------------------------------------------------------------
module prefix_varint_codec_unit
	import pvc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  byte_in,
	input  logic [31:0] value_in,
	input  logic [31:0] position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_kind,
	output logic [7:0]  byte_out,
	output logic [31:0] value_out,
	output logic        last
);

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [7:0]  byte_s1;
	logic [31:0] value_s1;
	logic [31:0] pos_s1;
	logic [2:0]  idx_q;

	logic        out_valid_q;
	logic        out_kind_q;
	logic [7:0]  byte_out_q;
	logic [31:0] value_out_q;
	logic        last_q;

	pvc_enc_t    enc;
	pvc_dec_t    dec;
	logic        is_enc;
	logic        has_result;
	logic        is_final;
	logic        out_free;
	logic        emit;
	logic        retire;
	logic        accept;

	// datapath units
	pvc_encoder u_enc (
		.mode     (mode_s1),
		.value_in (value_s1),
		.position (pos_s1),
		.index    (idx_q),
		.enc      (enc)
	);

	pvc_decoder u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (retire && !is_enc),
		.mode     (mode_s1),
		.byte_in  (byte_s1),
		.position (pos_s1),
		.dec      (dec)
	);

	// work register control
	assign is_enc     = mode_s1[1];
	assign has_result = is_enc || dec.done;
	assign is_final   = is_enc ? enc.final_byte : 1'b1;
	assign out_free   = !out_valid_q || !out_stall;
	assign emit       = valid_s1 && has_result && out_free;
	assign retire     = valid_s1 && (!has_result || (out_free && is_final));
	assign in_stall   = valid_s1 && !retire;
	assign accept     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept || retire) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			byte_s1  <= byte_in;
			value_s1 <= value_in;
			pos_s1   <= position;
		end
	end

	// encode byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (emit && is_enc) begin
			idx_q <= is_final ? 3'd0 : idx_q + 3'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (is_enc) begin
				out_kind_q  <= KIND_BYTE;
				byte_out_q  <= enc.code_byte;
				value_out_q <= '0;
				last_q      <= enc.final_byte;
			end else begin
				out_kind_q  <= KIND_VALUE;
				byte_out_q  <= '0;
				value_out_q <= dec.value;
				last_q      <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign byte_out  = byte_out_q;
	assign value_out = value_out_q;
	assign last      = last_q;

	// checks
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 3'd4)
		else $error("encode byte index out of range");

	a_idx_encode: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd0 |-> valid_s1 && is_enc)
		else $error("byte index set without an encode in progress");

	a_value_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_VALUE |-> last_q)
		else $error("decoded value not flagged last");

	a_retire_idx: assert property (@(posedge clk) disable iff (!arst_n)
		retire && is_enc |=> idx_q == 3'd0)
		else $error("byte index not cleared after encode");

endmodule

[bench/tb_prefix_varint_codec_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prefix_varint_codec_unit
// Self-checking bench for the prefix varint codec. A scoreboard keeps its own
// copy of the decode state and works out the code bytes and decoded values
// for every accepted input transaction. Each output transaction is compared
// field by field against the oldest expectation. Stimulus is a short directed
// list of code lengths, thresholds and jump edge cases, then random
// well-formed decode sequences, encodes and noise. Random gaps and stalls
// are applied on both channels.
// ----------------------------------------------------------------------------
module tb_prefix_varint_codec_unit
	import pvc_pkg::*;
();

	// scoreboard: decode state, encoder and queue of awaited results
	class varint_scoreboard;
		typedef struct {
			logic        kind;
			logic [7:0]  code_byte;
			logic [31:0] value;
			logic        fin;
		} codec_result_t;

		codec_result_t awaited_results[$];
		logic [31:0]   acc;
		logic [2:0]    bytes_left;
		logic          jump_code;
		logic [31:0]   base_pos;
		int            errors;
		int            dec_items;
		int            enc_items;
		int            values_seen;
		int            bytes_seen;
		int            len_hits[1:5];

		function new();
			acc        = '0;
			bytes_left = '0;
			jump_code  = 1'b0;
			base_pos   = '0;
			errors     = 0;
			dec_items  = 0;
			enc_items  = 0;
			values_seen = 0;
			bytes_seen = 0;
			foreach (len_hits[i]) len_hits[i] = 0;
		endfunction

		// queue the 1..5 code bytes of one value
		function void queue_code_bytes(logic [31:0] v);
			logic [7:0]    cb[5];
			int            n;
			codec_result_t r;
			if (v < LIM_1B) begin
				cb[0] = v[7:0];
				n = 1;
			end else if (v < LIM_2B) begin
				cb[0] = PFX_2B | v[15:8];
				cb[1] = v[7:0];
				n = 2;
			end else if (v < LIM_3B) begin
				cb[0] = PFX_3B | v[23:16];
				cb[1] = v[15:8];
				cb[2] = v[7:0];
				n = 3;
			end else if (v < LIM_4B) begin
				cb[0] = PFX_4B | v[31:24];
				cb[1] = v[23:16];
				cb[2] = v[15:8];
				cb[3] = v[7:0];
				n = 4;
			end else begin
				cb[0] = PFX_5B;
				cb[1] = v[31:24];
				cb[2] = v[23:16];
				cb[3] = v[15:8];
				cb[4] = v[7:0];
				n = 5;
			end
			len_hits[n]++;
			for (int i = 0; i < n; i++) begin
				r.kind      = KIND_BYTE;
				r.code_byte = cb[i];
				r.value     = '0;
				r.fin       = (i == n - 1);
				awaited_results.push_back(r);
			end
		endfunction

		// queue a decoded value, applying the jump offset if latched
		function void queue_decoded(logic [31:0] code);
			logic [31:0]   mag;
			logic [31:0]   off;
			codec_result_t r;
			mag = code >> 1;
			off = code[0] ? (32'd0 - mag) : mag;
			r.kind      = KIND_VALUE;
			r.code_byte = '0;
			r.value     = jump_code ? (base_pos + off) : code;
			r.fin       = 1'b1;
			awaited_results.push_back(r);
		endfunction

		// note one accepted input transaction
		function void accept_item(logic [1:0] m, logic [7:0] b, logic [31:0] v,
				logic [31:0] p);
			logic [31:0] d;
			if (m == MODE_ENC_VALUE) begin
				enc_items++;
				queue_code_bytes(v);
				return;
			end
			if (m == MODE_ENC_JUMP) begin
				enc_items++;
				d = v - p;
				if (d[31])
					queue_code_bytes(((32'd0 - d) << 1) | 32'd1);
				else
					queue_code_bytes(d << 1);
				return;
			end
			dec_items++;
			// prefix byte: latch kind and position, set length
			if (bytes_left == 3'd0) begin
				jump_code = (m == MODE_DEC_JUMP);
				base_pos  = p;
				if (b < PFX_2B) begin
					queue_decoded({24'd0, b});
				end else if (b < PFX_3B) begin
					acc = {24'd0, b & MASK_2B};
					bytes_left = 3'd1;
				end else if (b < PFX_4B) begin
					acc = {24'd0, b & MASK_3B};
					bytes_left = 3'd2;
				end else if (b < PFX_5B) begin
					acc = {24'd0, b & MASK_4B};
					bytes_left = 3'd3;
				end else begin
					acc = '0;
					bytes_left = 3'd4;
				end
				return;
			end
			// continuation byte
			acc = {acc[23:0], b};
			bytes_left = bytes_left - 3'd1;
			if (bytes_left == 3'd0)
				queue_decoded(acc);
		endfunction

		// compare one output transaction with the oldest expectation
		function void check_output(logic k, logic [7:0] b, logic [31:0] v, logic f);
			codec_result_t r;
			if (awaited_results.size() == 0) begin
				$error("unexpected result: out_kind %0d byte_out %02h value_out %08h last %0d",
					k, b, v, f);
				errors++;
				return;
			end
			r = awaited_results.pop_front();
			if (r.kind == KIND_VALUE) values_seen++;
			else bytes_seen++;
			if (k !== r.kind) begin
				$error("out_kind: expected %0d, got %0d", r.kind, k);
				errors++;
			end
			if (b !== r.code_byte) begin
				$error("byte_out: expected %02h, got %02h", r.code_byte, b);
				errors++;
			end
			if (v !== r.value) begin
				$error("value_out: expected %08h, got %08h", r.value, v);
				errors++;
			end
			if (f !== r.fin) begin
				$error("last: expected %0d, got %0d", r.fin, f);
				errors++;
			end
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction
	endclass

	localparam int ITEM_TARGET = 350;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [1:0]  mode      = MODE_DEC_PLAIN;
	logic [7:0]  byte_in   = '0;
	logic [31:0] value_in  = '0;
	logic [31:0] position  = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        out_kind;
	logic [7:0]  byte_out;
	logic [31:0] value_out;
	logic        last;

	varint_scoreboard sb = new();
	int items_sent = 0;
	int calm_left  = 0;

	prefix_varint_codec_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.byte_in   (byte_in),
		.value_in  (value_in),
		.position  (position),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_kind  (out_kind),
		.byte_out  (byte_out),
		.value_out (value_out),
		.last      (last)
	);

	// clock and reset
	always #6 clk = ~clk;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// input transactions into the scoreboard
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.accept_item(mode, byte_in, value_in, position);
	end

	// output transactions against the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_output(out_kind, byte_out, value_out, last);
	end

	// gap length: mostly none or short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// output stall pattern, with long calm stretches now and then
	initial begin
		int run;
		int hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				run = $urandom_range(60, 150);
			else
				run = $urandom_range(1, 12);
			repeat (run) @(posedge clk);
			hold = gap_len();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// present one transaction and wait for its acceptance
	task automatic push_item(input logic [1:0] m, input logic [7:0] b,
			input logic [31:0] v, input logic [31:0] p);
		mode     <= m;
		byte_in  <= b;
		value_in <= v;
		position <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// idle the input side between transactions
	task automatic pace_input();
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else if ($urandom_range(0, 39) == 0) begin
			calm_left = $urandom_range(30, 80);
			gap = 0;
		end else begin
			gap = gap_len();
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drive_item(input logic [1:0] m, input logic [7:0] b,
			input logic [31:0] v, input logic [31:0] p);
		push_item(m, b, v, p);
		pace_input();
	endtask

	// values spread over every code length and its thresholds
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, LIM_1B - 1);
			1: return $urandom_range(LIM_1B, LIM_2B - 1);
			2: return $urandom_range(LIM_2B, LIM_3B - 1);
			3: return $urandom_range(LIM_3B, LIM_4B - 1);
			4: return $urandom_range(LIM_4B, 32'hFFFF_FFFF);
			default: begin
				case ($urandom_range(0, 9))
					0: return 32'd0;
					1: return LIM_1B - 1;
					2: return LIM_1B;
					3: return LIM_2B - 1;
					4: return LIM_2B;
					5: return LIM_3B - 1;
					6: return LIM_3B;
					7: return LIM_4B - 1;
					8: return LIM_4B;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic logic [1:0] pick_dec_mode();
		return $urandom_range(0, 1) ? MODE_DEC_JUMP : MODE_DEC_PLAIN;
	endfunction

	task automatic send_encode_value();
		drive_item(MODE_ENC_VALUE, 8'($urandom), pick_value(), $urandom);
	endtask

	// jump target near the position, either direction, or anywhere
	task automatic send_encode_jump();
		logic [31:0] p;
		logic [31:0] delta;
		logic [31:0] t;
		p = $urandom;
		delta = pick_value() >> 1;
		if ($urandom_range(0, 9) == 0)
			t = $urandom;
		else if ($urandom_range(0, 1))
			t = p - delta;
		else
			t = p + delta;
		drive_item(MODE_ENC_JUMP, 8'($urandom), t, p);
	endtask

	// one complete code with random content, maybe with encodes inside
	task automatic send_code_sequence();
		int         len;
		logic [7:0] pfx;
		len = $urandom_range(1, 5);
		case (len)
			1: pfx = 8'($urandom_range(0, PFX_2B - 1));
			2: pfx = 8'($urandom_range(PFX_2B, PFX_3B - 1));
			3: pfx = 8'($urandom_range(PFX_3B, PFX_4B - 1));
			4: pfx = 8'($urandom_range(PFX_4B, PFX_5B - 1));
			default: pfx = 8'($urandom_range(PFX_5B, 8'hFF));
		endcase
		drive_item(pick_dec_mode(), pfx, $urandom, $urandom);
		for (int i = 1; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1)) send_encode_value();
				else send_encode_jump();
			end
			drive_item(pick_dec_mode(), 8'($urandom_range(0, 255)), $urandom, $urandom);
		end
	endtask

	// main stimulus
	initial begin
		int pick;
		wait (arst_n);
		@(posedge clk);

		// encoder thresholds and widest value
		drive_item(MODE_ENC_VALUE, 8'h00, 32'h0000_0000, 32'h0);
		drive_item(MODE_ENC_VALUE, 8'hFF, LIM_1B - 1, 32'hFFFF_FFFF);
		drive_item(MODE_ENC_VALUE, 8'h00, LIM_1B, 32'h0);
		drive_item(MODE_ENC_VALUE, 8'hFF, LIM_2B - 1, 32'h0);
		drive_item(MODE_ENC_VALUE, 8'h00, LIM_2B, 32'h0);
		drive_item(MODE_ENC_VALUE, 8'h00, LIM_3B, 32'h0);
		drive_item(MODE_ENC_VALUE, 8'h00, LIM_4B - 1, 32'h0);
		drive_item(MODE_ENC_VALUE, 8'h00, LIM_4B, 32'h0);
		drive_item(MODE_ENC_VALUE, 8'h00, 32'hFFFF_FFFF, 32'h0);
		// backward jump, and a distance of exactly half the range
		drive_item(MODE_ENC_JUMP, 8'h00, 32'h0000_0100, 32'h0000_0140);
		drive_item(MODE_ENC_JUMP, 8'h00, 32'h8000_1234, 32'h0000_1234);
		// one-byte codes, including the 0x7F prefix and a negative jump
		drive_item(MODE_DEC_PLAIN, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drive_item(MODE_DEC_PLAIN, 8'h7F, 32'h0, 32'h0);
		drive_item(MODE_DEC_JUMP, 8'h03, 32'h0, 32'h0000_1000);
		// largest two-byte code
		drive_item(MODE_DEC_PLAIN, 8'hBF, 32'h0, 32'h0);
		drive_item(MODE_DEC_PLAIN, 8'hFF, 32'h0, 32'h0);
		// jump code with an encode inside it and a changed mode and position
		drive_item(MODE_DEC_JUMP, 8'hC1, 32'h0, 32'hFFFF_FFF0);
		drive_item(MODE_ENC_VALUE, 8'h00, 32'h0000_4000, 32'h0);
		drive_item(MODE_DEC_PLAIN, 8'h00, 32'h0, 32'h1234_5678);
		drive_item(MODE_DEC_PLAIN, 8'h21, 32'h0, 32'h0);
		// five-byte code, low prefix bits set
		drive_item(MODE_DEC_PLAIN, 8'hFF, 32'h0, 32'h0);
		repeat (4) drive_item(MODE_DEC_PLAIN, 8'hFF, 32'h0, 32'h0);

		// random part
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_code_sequence();
			else if (pick < 80)
				send_encode_value();
			else if (pick < 95)
				send_encode_jump();
			else
				drive_item(pick_dec_mode(), 8'($urandom), $urandom, $urandom);
		end
		in_valid <= 1'b0;

		// drain
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d decode bytes giving %0d values, %0d encodes giving %0d bytes",
			sb.dec_items, sb.values_seen, sb.enc_items, sb.bytes_seen);
		$display("encode lengths 1..5 seen: %0d %0d %0d %0d %0d",
			sb.len_hits[1], sb.len_hits[2], sb.len_hits[3], sb.len_hits[4], sb.len_hits[5]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_prefix_varint_codec_unit: PASS");
		else
			$display("tb_prefix_varint_codec_unit: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("timeout with %0d results still awaited", sb.pending());
		$display("tb_prefix_varint_codec_unit: FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/pvc_pkg.sv
rtl/core/pvc_encoder.sv
rtl/core/pvc_decoder.sv
rtl/core/prefix_varint_codec_unit.sv
bench/tb_prefix_varint_codec_unit.sv
